FILE: src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and character codes for the space-to-tab compressor.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CfgW  = 5;

  typedef logic [CharW-1:0] char_t;
  typedef logic [CfgW-1:0]  cfg_t;

  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_NEWLINE = 8'h0A;
  localparam char_t CH_BLANK   = 8'h20;

  localparam cfg_t TAB_WIDTH_RESET = 5'd8;

endpackage

FILE: src/stc_intf.sv
// ----------------------------------------------------------------------------
// stc_intf
// Valid/ready channels for input text, output text and the tab width write.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t in_char;
  logic  end_text;

  modport source (output valid, output in_char, output end_text, input ready);
  modport sink (input valid, input in_char, input end_text, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  run_last;
  logic  text_done;

  modport source (output valid, output out_char, output run_last, output text_done,
                  input ready);
  modport sink (input valid, input out_char, input run_last, input text_done,
                output ready);
endinterface

interface stc_cfg_if import stc_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t tab_width;

  modport source (output valid, output tab_width, input ready);
  modport sink (input valid, input tab_width, output ready);
endinterface

FILE: src/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front
// Accepts text bytes, tracks held blanks and the tab stop column, and issues
// one emit command per byte that produces output.
// ----------------------------------------------------------------------------
module stc_front import stc_pkg::*; #(
  parameter int unsigned MaxTabWidth = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  cfg_t                             cfg_tab_width_i,
  input  logic                             in_valid_i,
  input  char_t                            in_char_i,
  input  logic                             in_end_text_i,
  output logic                             in_ready_o,
  output logic                             cmd_valid_o,
  output logic [$clog2(MaxTabWidth)+CharW+1:0] cmd_o,
  input  logic                             cmd_ready_i
);

  localparam int unsigned CntW  = $clog2(MaxTabWidth);
  localparam int unsigned TwW   = $clog2(MaxTabWidth + 1);
  localparam int unsigned StopW = $clog2(2 * MaxTabWidth);

  typedef struct packed {
    logic [CntW-1:0] blanks;
    logic            has_char;
    char_t           ch;
    logic            last_text;
  } cmd_t;

  cfg_t             tab_width_q;
  logic [TwW-1:0]   eff_width;
  logic [StopW-1:0] stop_q, stop_d, stop_sum, width_ext;
  logic [CntW-1:0]  pend_q, pend_d;
  logic             reduce, accept, blank_tab;
  cmd_t             cmd;

  always_comb begin
    if (tab_width_q == '0) begin
      eff_width = TwW'(1);
    end else if (int'(tab_width_q) > MaxTabWidth) begin
      eff_width = TwW'(MaxTabWidth);
    end else begin
      eff_width = TwW'(tab_width_q);
    end
  end

  assign width_ext  = StopW'(eff_width);
  assign reduce     = stop_q >= width_ext;
  assign in_ready_o = !reduce && cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign stop_sum   = stop_q + StopW'(pend_q) + StopW'(1);
  assign blank_tab  = stop_sum >= width_ext;

  always_comb begin
    stop_d         = stop_q;
    pend_d         = pend_q;
    cmd.blanks     = '0;
    cmd.has_char   = 1'b1;
    cmd.ch         = in_char_i;
    cmd.last_text  = in_end_text_i;
    cmd_valid_o    = 1'b0;
    if (reduce) begin
      stop_d = stop_q - width_ext;
    end else if (accept) begin
      case (in_char_i)
        CH_BLANK: begin
          if (blank_tab) begin
            cmd.ch      = CH_TAB;
            cmd_valid_o = 1'b1;
            stop_d      = '0;
            pend_d      = '0;
          end else if (in_end_text_i) begin
            cmd.blanks   = pend_q + CntW'(1);
            cmd.has_char = 1'b0;
            cmd_valid_o  = 1'b1;
            stop_d       = '0;
            pend_d       = '0;
          end else begin
            pend_d = pend_q + CntW'(1);
          end
        end
        CH_TAB: begin
          cmd_valid_o = 1'b1;
          stop_d      = '0;
          pend_d      = '0;
        end
        default: begin
          cmd.blanks  = pend_q;
          cmd_valid_o = 1'b1;
          pend_d      = '0;
          if (in_end_text_i || in_char_i == CH_NEWLINE) begin
            stop_d = '0;
          end else begin
            stop_d = stop_sum;
          end
        end
      endcase
    end
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= TAB_WIDTH_RESET;
      stop_q      <= '0;
      pend_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        tab_width_q <= cfg_tab_width_i;
      end
      stop_q <= stop_d;
      pend_q <= pend_d;
    end
  end

endmodule

FILE: src/stc_queue.sv
// ----------------------------------------------------------------------------
// stc_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module stc_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [Width-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/stc_back.sv
// ----------------------------------------------------------------------------
// stc_back
// Carries out emit commands: the held blanks first, then the byte if any,
// one word per cycle unless the output stalls, into a registered output.
// ----------------------------------------------------------------------------
module stc_back import stc_pkg::*; #(
  parameter int unsigned MaxTabWidth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  logic [$clog2(MaxTabWidth)+CharW+1:0] cmd_i,
  output logic                                 cmd_ready_o,
  output logic                                 out_valid_o,
  output char_t                                out_char_o,
  output logic                                 out_run_last_o,
  output logic                                 out_text_done_o,
  input  logic                                 out_ready_i
);

  localparam int unsigned CntW = $clog2(MaxTabWidth);

  typedef struct packed {
    logic [CntW-1:0] blanks;
    logic            has_char;
    char_t           ch;
    logic            last_text;
  } cmd_t;

  cmd_t            cmd_in, cur_q;
  logic            cur_valid_q, out_valid_q;
  logic [CntW-1:0] rem_q;
  logic            emit_blank, last, advance, load;
  char_t           out_char_q;
  logic            run_last_q, text_done_q;

  assign cmd_in      = cmd_i;
  assign emit_blank  = rem_q != '0;
  assign last        = emit_blank ? (rem_q == CntW'(1) && !cur_q.has_char) : 1'b1;
  assign advance     = cur_valid_q && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = !cur_valid_q || (advance && last);
  assign load        = cmd_valid_i && cmd_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        rem_q       <= cmd_in.blanks;
      end else if (advance && last) begin
        cur_valid_q <= 1'b0;
      end else if (advance && emit_blank) begin
        rem_q <= rem_q - CntW'(1);
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_in;
    end
    if (advance) begin
      out_char_q  <= emit_blank ? CH_BLANK : cur_q.ch;
      run_last_q  <= last;
      text_done_q <= last && cur_q.last_text;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign out_run_last_o  = run_last_q;
  assign out_text_done_o = text_done_q;

endmodule

FILE: src/space_to_tab_compressor_unit.sv
// ----------------------------------------------------------------------------
// space_to_tab_compressor_unit
// Blank-to-tab conversion on a byte stream with a programmable tab width.
// ----------------------------------------------------------------------------
// The block takes one text byte per accepted word and emits the bytes it
// causes, one output word per cycle while the output is ready, with run_last
// on the last one and text_done on the last byte of a text. The front accepts
// a byte while the two-entry command queue has room. After a byte brings the
// column to the tab width or beyond, and after the tab width is lowered, the
// front subtracts the tab width from the column until it is below the width
// before it accepts again. The back emits a byte that flushes k held blanks
// as k blank words and then the byte, and a byte's first output word passes
// through the queue entry, the back's command register and its output
// register. Ordinary text pauses to wrap the column at each tab stop, while
// a flush keeps the back busy and the input stops once the queue is full.
// ----------------------------------------------------------------------------
module space_to_tab_compressor_unit import stc_pkg::*; #(
  parameter int unsigned MAX_TAB_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_cfg_if.sink   cfg_i,
  stc_in_if.sink    in_i,
  stc_out_if.source out_o
);

  localparam int unsigned CmdW = $clog2(MAX_TAB_WIDTH) + CharW + 2;

  logic            front_valid, front_ready, back_valid, back_ready;
  logic [CmdW-1:0] front_cmd, back_cmd;

  assign cfg_i.ready = 1'b1;

  stc_front #(
    .MaxTabWidth (MAX_TAB_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_tab_width_i (cfg_i.tab_width),
    .in_valid_i      (in_i.valid),
    .in_char_i       (in_i.in_char),
    .in_end_text_i   (in_i.end_text),
    .in_ready_o      (in_i.ready),
    .cmd_valid_o     (front_valid),
    .cmd_o           (front_cmd),
    .cmd_ready_i     (front_ready)
  );

  stc_queue #(
    .Width (CmdW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_cmd),
    .push_ready_o (front_ready),
    .pop_valid_o  (back_valid),
    .pop_data_o   (back_cmd),
    .pop_ready_i  (back_ready)
  );

  stc_back #(
    .MaxTabWidth (MAX_TAB_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (back_valid),
    .cmd_i           (back_cmd),
    .cmd_ready_o     (back_ready),
    .out_valid_o     (out_o.valid),
    .out_char_o      (out_o.out_char),
    .out_run_last_o  (out_o.run_last),
    .out_text_done_o (out_o.text_done),
    .out_ready_i     (out_o.ready)
  );

endmodule

FILE: src/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks on the output stream of the space-to-tab compressor.
// ----------------------------------------------------------------------------
module stc_checker import stc_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input char_t out_char_i,
  input logic  run_last_i,
  input logic  text_done_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(run_last_i) && $stable(text_done_i))
    else $error("Stalled output word changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !run_last_i |-> out_char_i == CH_BLANK)
    else $error("Only flushed blanks may precede the last byte of a run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && text_done_i |-> run_last_i)
    else $error("End of text marked on a byte that does not close its run.");

endmodule

bind space_to_tab_compressor_unit stc_checker u_stc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .run_last_i  (out_o.run_last),
  .text_done_i (out_o.text_done)
);

FILE: sim/space_to_tab_compressor_unit_checker.sv
// ----------------------------------------------------------------------------
// space_to_tab_compressor_unit_checker
// Watches the tab width, input and output channels of the space-to-tab
// compressor. It predicts the output words of every accepted input word from
// its own copy of the tab width, the held blank count and the stop column,
// and compares each accepted output word field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module space_to_tab_compressor_unit_checker import stc_pkg::*; #(
  parameter int unsigned MAX_TAB_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stc_cfg_if          cfg_i,
  stc_in_if           text_in_i,
  stc_out_if          text_out_i,
  output int unsigned mismatches_o,
  output int unsigned words_waiting_o,
  output int unsigned words_checked_o,
  output int unsigned tabs_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    char_t out_char;
    logic  run_last;
    logic  text_done;
  } text_word_t;

  text_word_t  expected_text[$];
  text_word_t  step_words[$];
  text_word_t  oldest_word;
  cfg_t        tab_width_q;
  int unsigned held_blanks;
  int unsigned stop_col;
  int unsigned mismatch_cnt;
  int unsigned checked_cnt;
  int unsigned tab_cnt;

  task automatic push_char(input char_t c);
    step_words.push_back('{out_char: c, run_last: 1'b0, text_done: 1'b0});
  endtask

  task automatic flush_held(input int unsigned width);
    repeat (held_blanks) push_char(CH_BLANK);
    stop_col    = (stop_col + held_blanks) % width;
    held_blanks = 0;
  endtask

  task automatic predict_entab(input char_t c, input logic last);
    int unsigned width;
    text_word_t  tail;
    if (tab_width_q == '0) begin
      width = 1;
    end else if (tab_width_q > MAX_TAB_WIDTH) begin
      width = MAX_TAB_WIDTH;
    end else begin
      width = tab_width_q;
    end
    step_words.delete();
    stop_col = stop_col % width;
    if (c == CH_BLANK) begin
      held_blanks++;
      if (stop_col + held_blanks >= width) begin
        push_char(CH_TAB);
        stop_col    = 0;
        held_blanks = 0;
      end
    end else if (c == CH_TAB) begin
      held_blanks = 0;
      push_char(CH_TAB);
      stop_col = 0;
    end else begin
      flush_held(width);
      push_char(c);
      stop_col = (c == CH_NEWLINE) ? 0 : (stop_col + 1) % width;
    end
    if (last) begin
      flush_held(width);
      stop_col    = 0;
      held_blanks = 0;
    end
    if (step_words.size() > 0) begin
      tail           = step_words[step_words.size()-1];
      tail.run_last  = 1'b1;
      tail.text_done = last;
      step_words[step_words.size()-1] = tail;
    end
    foreach (step_words[k]) expected_text.push_back(step_words[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_text.delete();
      tab_width_q     = TAB_WIDTH_RESET;
      held_blanks     = 0;
      stop_col        = 0;
      mismatch_cnt    = 0;
      checked_cnt     = 0;
      tab_cnt         = 0;
      mismatches_o    <= 0;
      words_waiting_o <= 0;
      words_checked_o <= 0;
      tabs_checked_o  <= 0;
    end else begin
      if (text_out_i.valid && text_out_i.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected output word: out_char %h run_last %b text_done %b",
                 text_out_i.out_char, text_out_i.run_last, text_out_i.text_done);
          mismatch_cnt++;
        end else begin
          oldest_word = expected_text.pop_front();
          checked_cnt++;
          if (text_out_i.out_char == CH_TAB) tab_cnt++;
          if (text_out_i.out_char !== oldest_word.out_char) begin
            $error("out_char: expected %h, actual %h",
                   oldest_word.out_char, text_out_i.out_char);
            mismatch_cnt++;
          end
          if (text_out_i.run_last !== oldest_word.run_last) begin
            $error("run_last: expected %b, actual %b",
                   oldest_word.run_last, text_out_i.run_last);
            mismatch_cnt++;
          end
          if (text_out_i.text_done !== oldest_word.text_done) begin
            $error("text_done: expected %b, actual %b",
                   oldest_word.text_done, text_out_i.text_done);
            mismatch_cnt++;
          end
        end
      end
      if (text_in_i.valid && text_in_i.ready) begin
        predict_entab(text_in_i.in_char, text_in_i.end_text);
      end
      if (cfg_i.valid && cfg_i.ready) begin
        tab_width_q = cfg_i.tab_width;
      end
      mismatches_o    <= mismatch_cnt;
      words_waiting_o <= expected_text.size();
      words_checked_o <= checked_cnt;
      tabs_checked_o  <= tab_cnt;
    end
  end

endmodule

FILE: sim/space_to_tab_compressor_unit_test.sv
// ----------------------------------------------------------------------------
// space_to_tab_compressor_unit_test
// Testbench top for the space-to-tab compressor. It drives a short directed
// text, then random text made mostly of words, blank runs, newlines and tabs
// under a series of tab widths including the clamped extremes, with random
// idling on both channels and one long output stall. The checker beside the
// block predicts and compares every output word.
// ----------------------------------------------------------------------------
module space_to_tab_compressor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stc_pkg::*;

  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseItems  = 26;

  typedef enum logic [2:0] {TokWord, TokBlanks, TokNewline, TokTab, TokNoise} token_e;

  logic        clk_i;
  logic        rst_ni;
  bit          quiet;
  bit          tx_gappy;
  bit          rx_stalls;
  bit          hold_req;
  int unsigned items_sent;
  int unsigned texts_ended;
  int unsigned cfg_writes;
  int unsigned mismatches;
  int unsigned words_waiting;
  int unsigned words_checked;
  int unsigned tabs_checked;
  cfg_t        width_plan [8];

  stc_cfg_if cfg_w ();
  stc_in_if  in_w ();
  stc_out_if out_w ();

  space_to_tab_compressor_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_w),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  space_to_tab_compressor_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_w),
    .text_in_i       (in_w),
    .text_out_i      (out_w),
    .mismatches_o    (mismatches),
    .words_waiting_o (words_waiting),
    .words_checked_o (words_checked),
    .tabs_checked_o  (tabs_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("space_to_tab_compressor_unit_test NOT OK");
    $finish;
  end

  task automatic send_word(input char_t c, input logic last);
    if (!quiet && tx_gappy && $urandom_range(0, 3) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_w.valid    <= 1'b1;
    in_w.in_char  <= c;
    in_w.end_text <= last;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    items_sent++;
    if (last) texts_ended++;
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (words_waiting != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tab_width(input cfg_t width);
    cfg_w.valid     <= 1'b1;
    cfg_w.tab_width <= width;
    @(posedge clk_i);
    while (!cfg_w.ready) @(posedge clk_i);
    cfg_w.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_text(input int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned pick;
    int unsigned i;
    token_e      tok;
    char_t       c;
    logic        last;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) tok = TokWord;
      else if (pick < 6) tok = TokBlanks;
      else if (pick == 6) tok = TokNewline;
      else if (pick == 7) tok = TokTab;
      else tok = TokNoise;
      if ($urandom_range(0, 7) == 0) tx_gappy = !tx_gappy;
      case (tok)
        TokWord:   run = $urandom_range(1, 6);
        TokBlanks: run = $urandom_range(1, 18);
        TokNoise:  run = $urandom_range(1, 3);
        default:   run = 1;
      endcase
      for (i = 0; i < run && left > 0; i++) begin
        case (tok)
          TokWord:    c = char_t'($urandom_range(8'h21, 8'h7E));
          TokBlanks:  c = CH_BLANK;
          TokNewline: c = CH_NEWLINE;
          TokTab:     c = CH_TAB;
          default:    c = char_t'($urandom_range(0, 255));
        endcase
        last = ($urandom_range(0, 39) == 0) || (left == 1 && $urandom_range(0, 1) == 1);
        send_word(c, last);
        left--;
      end
    end
  endtask

  initial begin
    out_w.ready = 1'b0;
    rx_stalls   = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_w.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && rx_stalls && $urandom_range(0, 3) == 0) begin
        out_w.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_w.ready <= 1'b1;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) rx_stalls = !rx_stalls;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    quiet           = 1'b0;
    tx_gappy        = 1'b1;
    hold_req        = 1'b0;
    items_sent      = 0;
    texts_ended     = 0;
    cfg_writes      = 0;
    cfg_w.valid     = 1'b0;
    cfg_w.tab_width = TAB_WIDTH_RESET;
    in_w.valid      = 1'b0;
    in_w.in_char    = '0;
    in_w.end_text   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A width above the maximum clamps, so fifteen held blanks then a byte
    // produce the longest burst of output words.
    write_tab_width(5'd31);
    repeat (15) send_word(CH_BLANK, 1'b0);
    send_word("q", 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_word(CH_NEWLINE, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_word(CH_BLANK, 1'b1);

    width_plan = '{5'd8, 5'd0, 5'd1, 5'd16, 5'd3, 5'd31, 5'd2, 5'd8};
    width_plan[7] = cfg_t'($urandom_range(0, 31));
    foreach (width_plan[p]) begin
      wait_idle();
      write_tab_width(width_plan[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == 7) quiet = 1'b1;
      send_text(PhaseItems);
    end

    wait_idle();
    $display("Sent %0d text bytes in %0d texts over %0d tab width writes.",
             items_sent, texts_ended, cfg_writes);
    $display("Checked %0d output words, %0d of them tabs.", words_checked, tabs_checked);
    if (mismatches == 0 && words_waiting == 0) begin
      $display("space_to_tab_compressor_unit_test OK");
    end else begin
      $display("space_to_tab_compressor_unit_test NOT OK");
    end
    $finish;
  end

endmodule
